[hw/rtl/eaa_pkg.sv]
// ----------------------------------------------------------------------------
// eaa_pkg
// Types and constants of the encoder acceleration accumulator: request and
// event layouts, request and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package eaa_pkg;

  localparam int ENC_W      = 3;
  localparam int MAX_ENC    = 2 ** ENC_W;
  localparam int VALUE_W    = 14;
  localparam int POS_W      = 32;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 8;
  localparam int THRESH_W   = 16;
  localparam int PROD_W     = POS_W + GAIN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd16383;

  localparam logic [1:0] REQ_TICK       = 2'd0;
  localparam logic [1:0] REQ_SAMPLE     = 2'd1;
  localparam logic [1:0] REQ_HOST_WRITE = 2'd2;
  localparam logic [1:0] REQ_SEED       = 2'd3;

  localparam logic EVT_VALUE  = 1'b0;
  localparam logic EVT_BUTTON = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_THRESH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SLOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MID     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FAST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FASTEST = 3'd7;

  localparam logic [GAIN_W-1:0]   RST_TICK_MS      = 8'd10;
  localparam logic [THRESH_W-1:0] RST_SLOW_THRESH  = 16'd120;
  localparam logic [THRESH_W-1:0] RST_MID_THRESH   = 16'd60;
  localparam logic [THRESH_W-1:0] RST_FAST_THRESH  = 16'd30;
  localparam logic [GAIN_W-1:0]   RST_GAIN_SLOW    = 8'd2;
  localparam logic [GAIN_W-1:0]   RST_GAIN_MID     = 8'd32;
  localparam logic [GAIN_W-1:0]   RST_GAIN_FAST    = 8'd64;
  localparam logic [GAIN_W-1:0]   RST_GAIN_FASTEST = 8'd128;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [ENC_W-1:0]        encoder_index;
    logic signed [POS_W-1:0] raw_position;
    logic                    switch_level;
    logic [VALUE_W-1:0]      host_value;
  } req_item_t;

  typedef struct packed {
    logic               event_kind;
    logic [ENC_W-1:0]   event_encoder;
    logic [VALUE_W-1:0] new_value;
    logic               button_pressed;
    logic               last_event;
  } evt_item_t;

endpackage

[hw/rtl/encoder_accel_accumulator.sv]
// ----------------------------------------------------------------------------
// encoder_accel_accumulator
// Per-encoder 14-bit value with velocity-dependent gain, button edge events
// and a saturating millisecond clock.
// ----------------------------------------------------------------------------
// A request is taken into an input register and fully processed from there:
// the channel state is read, updated and its events are written into a
// two-entry event queue, so one request per cycle is accepted while the
// request side is not stalled. A request raising both a value and a button
// event needs two queue slots and holds the input register until they are
// free; the queue drains one event per cycle while evt_stall is low. The
// first event of a request is offered from the event queue register, which
// follows the input register. A stalled event queue stalls the request side.
// Only channels below NUM_CHANNELS (and below eight) exist; requests to other
// channels are dropped.
module encoder_accel_accumulator #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  eaa_pkg::req_item_t                 req_data,
  output logic                               evt_valid,
  input  logic                               evt_stall,
  output eaa_pkg::evt_item_t                 evt_data,
  input  logic                               cfg_write,
  input  logic [eaa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eaa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = (NUM_CHANNELS < eaa_pkg::MAX_ENC) ? NUM_CHANNELS : eaa_pkg::MAX_ENC;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [eaa_pkg::GAIN_W-1:0]   tick_ms;
  logic [eaa_pkg::THRESH_W-1:0] slow_thresh;
  logic [eaa_pkg::THRESH_W-1:0] mid_thresh;
  logic [eaa_pkg::THRESH_W-1:0] fast_thresh;
  logic [eaa_pkg::GAIN_W-1:0]   gain_slow;
  logic [eaa_pkg::GAIN_W-1:0]   gain_mid;
  logic [eaa_pkg::GAIN_W-1:0]   gain_fast;
  logic [eaa_pkg::GAIN_W-1:0]   gain_fastest;

  // channel state
  logic [eaa_pkg::POS_W-1:0]   last_raw       [DEPTH];
  logic [eaa_pkg::TIME_W-1:0]  last_move_time [DEPTH];
  logic [eaa_pkg::VALUE_W-1:0] accum_value    [DEPTH];
  logic                        echo_guard     [DEPTH];
  logic                        button_state   [DEPTH];
  logic [eaa_pkg::TIME_W-1:0]  clock_ms;

  // input register
  logic               req_full;
  eaa_pkg::req_item_t req_r;

  // event queue
  eaa_pkg::evt_item_t evq [2];
  logic [1:0]         ev_count;

  logic                          accept;
  logic                          fire;
  logic                          pop;
  logic [1:0]                    cnt_rem;
  logic [1:0]                    nres;
  logic [IDX_W-1:0]              ch;
  logic                          ch_ok;
  logic                          is_tick;
  logic                          is_sample;
  logic                          is_host;
  logic                          is_seed;
  logic [eaa_pkg::POS_W-1:0]     raw_u;
  logic [eaa_pkg::POS_W-1:0]     delta;
  logic                          moved;
  logic                          neg;
  logic [eaa_pkg::POS_W-1:0]     mag;
  logic [eaa_pkg::TIME_W-1:0]    dt;
  logic [eaa_pkg::GAIN_W-1:0]    gain;
  logic [eaa_pkg::PROD_W-1:0]    prod;
  logic [eaa_pkg::VALUE_W-1:0]   oldv;
  logic [eaa_pkg::VALUE_W-1:0]   headroom;
  logic [eaa_pkg::VALUE_W-1:0]   newv;
  logic                          pressed;
  logic                          guarded;
  logic                          do_move;
  logic                          val_evt;
  logic                          btn_evt;
  logic [eaa_pkg::TIME_W:0]      clock_sum;
  logic [eaa_pkg::TIME_W-1:0]    clock_ms_next;
  eaa_pkg::evt_item_t            res0;
  eaa_pkg::evt_item_t            res1;
  eaa_pkg::evt_item_t            evq_next [2];
  logic [1:0]                    ev_count_next;

  // request decode and channel arithmetic
  always_comb begin
    ch        = req_r.encoder_index[IDX_W-1:0];
    ch_ok     = (32'(req_r.encoder_index) < 32'(NUM_CHANNELS));
    is_tick   = (req_r.req_type == eaa_pkg::REQ_TICK);
    is_sample = (req_r.req_type == eaa_pkg::REQ_SAMPLE) && ch_ok;
    is_host   = (req_r.req_type == eaa_pkg::REQ_HOST_WRITE) && ch_ok;
    is_seed   = (req_r.req_type == eaa_pkg::REQ_SEED) && ch_ok;

    raw_u = req_r.raw_position;
    delta = raw_u - last_raw[ch];
    moved = (delta != '0);
    neg   = delta[eaa_pkg::POS_W-1];
    mag   = neg ? (~delta + 1'b1) : delta;
    dt    = clock_ms - last_move_time[ch];

    if (dt >= eaa_pkg::TIME_W'(slow_thresh)) begin
      gain = gain_slow;
    end else if (dt >= eaa_pkg::TIME_W'(mid_thresh)) begin
      gain = gain_mid;
    end else if (dt >= eaa_pkg::TIME_W'(fast_thresh)) begin
      gain = gain_fast;
    end else begin
      gain = gain_fastest;
    end

    prod     = eaa_pkg::PROD_W'(mag) * eaa_pkg::PROD_W'(gain);
    oldv     = accum_value[ch];
    headroom = eaa_pkg::VALUE_MAX - oldv;
    if (neg) begin
      newv = (prod >= eaa_pkg::PROD_W'(oldv)) ? '0 : oldv - prod[eaa_pkg::VALUE_W-1:0];
    end else begin
      newv = (prod >= eaa_pkg::PROD_W'(headroom)) ? eaa_pkg::VALUE_MAX
                                                  : oldv + prod[eaa_pkg::VALUE_W-1:0];
    end

    pressed = ~req_r.switch_level;
    guarded = is_sample && moved && echo_guard[ch];
    do_move = is_sample && moved && !echo_guard[ch];
    val_evt = do_move && (newv != oldv);
    btn_evt = is_sample && !guarded && (pressed != button_state[ch]);
    nres    = {1'b0, val_evt} + {1'b0, btn_evt};

    clock_sum     = {1'b0, clock_ms} + (eaa_pkg::TIME_W + 1)'(tick_ms);
    clock_ms_next = clock_sum[eaa_pkg::TIME_W] ? '1 : clock_sum[eaa_pkg::TIME_W-1:0];
  end

  // event formatting
  always_comb begin
    res0 = '0;
    res1 = '0;
    if (val_evt) begin
      res0.event_kind    = eaa_pkg::EVT_VALUE;
      res0.event_encoder = req_r.encoder_index;
      res0.new_value     = newv;
      res0.last_event    = !btn_evt;
      res1.event_kind     = eaa_pkg::EVT_BUTTON;
      res1.event_encoder  = req_r.encoder_index;
      res1.button_pressed = pressed;
      res1.last_event     = 1'b1;
    end else begin
      res0.event_kind     = eaa_pkg::EVT_BUTTON;
      res0.event_encoder  = req_r.encoder_index;
      res0.button_pressed = pressed;
      res0.last_event     = 1'b1;
    end
  end

  // handshake and queue
  always_comb begin
    pop       = (ev_count != 2'd0) && !evt_stall;
    cnt_rem   = ev_count - {1'b0, pop};
    fire      = req_full && ((3'(cnt_rem) + 3'(nres)) <= 3'd2);
    req_stall = req_full && !fire;
    accept    = req_valid && !req_stall;

    evq_next[0] = pop ? evq[1] : evq[0];
    evq_next[1] = evq[1];
    if (fire) begin
      case (cnt_rem)
        2'd0: begin
          evq_next[0] = res0;
          evq_next[1] = res1;
        end
        2'd1: begin
          evq_next[1] = res0;
        end
        default: begin
        end
      endcase
    end
    ev_count_next = cnt_rem + (fire ? nres : 2'd0);
  end

  assign evt_valid = (ev_count != 2'd0);
  assign evt_data  = evq[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms      <= eaa_pkg::RST_TICK_MS;
      slow_thresh  <= eaa_pkg::RST_SLOW_THRESH;
      mid_thresh   <= eaa_pkg::RST_MID_THRESH;
      fast_thresh  <= eaa_pkg::RST_FAST_THRESH;
      gain_slow    <= eaa_pkg::RST_GAIN_SLOW;
      gain_mid     <= eaa_pkg::RST_GAIN_MID;
      gain_fast    <= eaa_pkg::RST_GAIN_FAST;
      gain_fastest <= eaa_pkg::RST_GAIN_FASTEST;
    end else if (cfg_write) begin
      case (cfg_index)
        eaa_pkg::REG_TICK_MS:      tick_ms      <= cfg_data[eaa_pkg::GAIN_W-1:0];
        eaa_pkg::REG_SLOW_THRESH:  slow_thresh  <= cfg_data[eaa_pkg::THRESH_W-1:0];
        eaa_pkg::REG_MID_THRESH:   mid_thresh   <= cfg_data[eaa_pkg::THRESH_W-1:0];
        eaa_pkg::REG_FAST_THRESH:  fast_thresh  <= cfg_data[eaa_pkg::THRESH_W-1:0];
        eaa_pkg::REG_GAIN_SLOW:    gain_slow    <= cfg_data[eaa_pkg::GAIN_W-1:0];
        eaa_pkg::REG_GAIN_MID:     gain_mid     <= cfg_data[eaa_pkg::GAIN_W-1:0];
        eaa_pkg::REG_GAIN_FAST:    gain_fast    <= cfg_data[eaa_pkg::GAIN_W-1:0];
        eaa_pkg::REG_GAIN_FASTEST: gain_fastest <= cfg_data[eaa_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        last_raw[i]       <= '0;
        last_move_time[i] <= '0;
        accum_value[i]    <= '0;
        echo_guard[i]     <= 1'b0;
        button_state[i]   <= 1'b0;
      end
    end else if (fire) begin
      if (is_tick) begin
        clock_ms <= clock_ms_next;
      end
      if (is_sample || is_host || is_seed) begin
        last_raw[ch] <= raw_u;
      end
      if (is_host) begin
        accum_value[ch] <= req_r.host_value;
        echo_guard[ch]  <= 1'b1;
      end
      if (is_seed) begin
        accum_value[ch] <= '0;
      end
      if (guarded) begin
        echo_guard[ch] <= 1'b0;
      end
      if (do_move) begin
        last_move_time[ch] <= clock_ms;
        accum_value[ch]    <= newv;
      end
      if (btn_evt) begin
        button_state[ch] <= pressed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      ev_count <= 2'd0;
    end else begin
      req_full <= accept || (req_full && !fire);
      ev_count <= ev_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_data;
    end
    evq[0] <= evq_next[0];
    evq[1] <= evq_next[1];
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    ev_count <= 2'd2)
    else $error("event queue over capacity");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_stall && !evt_data.last_event) |=> evt_valid)
    else $error("second event of a request missing");

  a_clock_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (clock_ms >= $past(clock_ms)))
    else $error("millisecond clock went backwards");

endmodule
